[rtl/rmmn_pkg.sv]
// Package for the RGB min/max normalise unit.
// Holds widths, register indexes, the sequencer state type and the lane control struct.
// No dependencies.
package rmmn_pkg;

    // Pixel and arithmetic widths
    localparam int PIX_W     = 8;
    localparam int DIFF_W    = PIX_W + 1;
    localparam int PROD_W    = 2 * PIX_W;
    localparam int VAL_W     = PROD_W + 2;
    localparam int DIV_STEPS = PROD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int LANES     = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [PIX_W-1:0] PIX_MIN = '0;
    localparam logic [PIX_W-1:0] PIX_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LOW_RED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HIGH_RED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LOW_GREEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HIGH_GREEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LOW_BLUE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HIGH_BLUE  = 3'd5;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } seq_state_t;

    // Control from the sequencer to every lane
    typedef struct packed {
        logic scan;
        logic restart;
        logic load;
        logic mul;
        logic div_step;
    } lane_ctrl_t;

endpackage

[rtl/rgb_min_max_normalize_unit.sv]
// Channel  | Direction | Ports                           | Content
// s_       | in        | s_tvalid s_tready s_tdata s_tuser | pixel, mode and frame start
// m_       | out       | m_tvalid m_tready m_tdata       | stretched pixel
// cfg_     | in        | cfg_wr_en cfg_index cfg_wdata   | target low/high per channel
//
// A scan transaction updates min/max at the edge that accepts it.
// A map transaction is captured at its accepting edge; m_tvalid rises after one multiply,
// 16 steps of the serial divider in each lane and one output load. The next transaction
// is taken once the result sits in the output register, so while a map transaction is
// in progress no new transaction, scan or map, is accepted.
// Reset (aresetn, synchronous, active low) sets min to 255, max to 0 and the targets
// to 0..255. A stalled output holds the sequencer in its last state until taken.
module rgb_min_max_normalize_unit
    import rmmn_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [LANES*PIX_W-1:0] s_tdata,   // in_red, in_green, in_blue
    input  logic [1:0]             s_tuser,   // mode, frame_start
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [LANES*PIX_W-1:0] m_tdata,   // out_red, out_green, out_blue
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [PIX_W-1:0]       cfg_wdata
);

    seq_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PIX_W-1:0]  low_reg  [LANES];
    logic [PIX_W-1:0]  high_reg [LANES];
    logic [PIX_W-1:0]  lane_res [LANES];
    lane_ctrl_t        ctrl;
    logic              accept;
    logic              out_load;
    logic              out_free;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LANES; i++) begin
                low_reg[i]  <= PIX_MIN;
                high_reg[i] <= PIX_MAX;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TARGET_LOW_RED:    low_reg[0]  <= cfg_wdata;
                REG_TARGET_HIGH_RED:   high_reg[0] <= cfg_wdata;
                REG_TARGET_LOW_GREEN:  low_reg[1]  <= cfg_wdata;
                REG_TARGET_HIGH_GREEN: high_reg[1] <= cfg_wdata;
                REG_TARGET_LOW_BLUE:   low_reg[2]  <= cfg_wdata;
                REG_TARGET_HIGH_BLUE:  high_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    assign accept = s_tvalid && s_tready;

    // Next state and lane control
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        s_tready      = 1'b0;
        out_load      = 1'b0;
        ctrl.scan     = 1'b0;
        ctrl.restart  = s_tuser[1];
        ctrl.load     = 1'b0;
        ctrl.mul      = 1'b0;
        ctrl.div_step = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                ctrl.scan = s_tvalid && !s_tuser[0];
                ctrl.load = s_tvalid && s_tuser[0];
                if (s_tvalid && s_tuser[0]) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                ctrl.mul   = 1'b1;
                count_next = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                ctrl.div_step = 1'b1;
                count_next    = count_reg + 1'b1;
                if (count_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                out_load = 1'b1;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // One lane per colour channel
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        rmmn_lane u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .pixel       (s_tdata[g*PIX_W +: PIX_W]),
            .target_low  (low_reg[g]),
            .target_high (high_reg[g]),
            .result      (lane_res[g])
        );
    end

    rmmn_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (out_load),
        .res_red   (lane_res[0]),
        .res_green (lane_res[1]),
        .res_blue  (lane_res[2]),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .free      (out_free)
    );

    // A map transaction goes straight to the multiply cycle
    a_map_to_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tuser[0] |=> state_reg == ST_MUL)
        else $error("map transaction did not start the multiply");

    // Division always starts from a cleared step count
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL |=> state_reg == ST_DIV && count_reg == '0)
        else $error("divide did not start at step zero");

    // A result appears only after the output state
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output state");

endmodule

[rtl/rmmn_div.sv]
// Serial restoring divider, one quotient bit per step.
// Unsigned dividend of PROD_W bits over a PIX_W-bit divisor.
// Depends on rmmn_pkg.
module rmmn_div
    import rmmn_pkg::*;
(
    input  logic              aclk,
    input  logic              load,
    input  logic              step,
    input  logic [PROD_W-1:0] dividend,
    input  logic [PIX_W-1:0]  divisor,
    output logic [PROD_W-1:0] quotient
);

    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [PIX_W-1:0]  rem_reg, rem_next;
    logic [PIX_W-1:0]  dsr_reg;
    logic [PIX_W:0]    shifted;
    logic [PIX_W:0]    trial;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        shifted  = {rem_reg, quo_reg[PROD_W-1]};
        trial    = shifted - {1'b0, dsr_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (load) begin
            rem_next = '0;
            quo_next = dividend;
        end else if (step) begin
            if (shifted >= {1'b0, dsr_reg}) begin
                rem_next = trial[PIX_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[PIX_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (load) begin
            dsr_reg <= divisor;
        end
    end

    assign quotient = quo_reg;

endmodule

[rtl/rmmn_lane.sv]
// One colour channel: min/max tracking, stretch multiply, divide and saturate.
// Instantiates rmmn_div; driven by the sequencer through lane_ctrl_t.
// Depends on rmmn_pkg.
module rmmn_lane
    import rmmn_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  lane_ctrl_t       ctrl,
    input  logic [PIX_W-1:0] pixel,
    input  logic [PIX_W-1:0] target_low,
    input  logic [PIX_W-1:0] target_high,
    output logic [PIX_W-1:0] result
);

    logic [PIX_W-1:0]  min_reg, min_next;
    logic [PIX_W-1:0]  max_reg, max_next;
    logic [PIX_W-1:0]  base_min, base_max;
    logic [DIFF_W-1:0] diff_reg, span_reg, den_reg;
    logic [PIX_W-1:0]  low_reg;
    logic              neg_reg;
    logic              flat_reg;
    logic [DIFF_W-1:0] diff_abs, span_abs, den_abs;
    logic [PROD_W-1:0] product;
    logic [PROD_W-1:0] quo_mag;
    logic [VAL_W-1:0]  quo_signed;
    logic [VAL_W-1:0]  value;

    // Track min and max; a restart folds the pixel into the reset values
    always_comb begin
        base_min = ctrl.restart ? PIX_MAX : min_reg;
        base_max = ctrl.restart ? PIX_MIN : max_reg;
        min_next = min_reg;
        max_next = max_reg;
        if (ctrl.scan) begin
            min_next = (pixel < base_min) ? pixel : base_min;
            max_next = (pixel > base_max) ? pixel : base_max;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= PIX_MAX;
            max_reg <= PIX_MIN;
        end else begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    // Capture the signed differences of a map transaction
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            diff_reg <= {1'b0, pixel} - {1'b0, min_reg};
            den_reg  <= {1'b0, max_reg} - {1'b0, min_reg};
            span_reg <= {1'b0, target_high} - {1'b0, target_low};
            low_reg  <= target_low;
        end
    end

    // Magnitudes and sign for the unsigned multiply and divide
    always_comb begin
        diff_abs = diff_reg[DIFF_W-1] ? (~diff_reg + 1'b1) : diff_reg;
        span_abs = span_reg[DIFF_W-1] ? (~span_reg + 1'b1) : span_reg;
        den_abs  = den_reg[DIFF_W-1]  ? (~den_reg + 1'b1)  : den_reg;
        product  = diff_abs[PIX_W-1:0] * span_abs[PIX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul) begin
            neg_reg  <= diff_reg[DIFF_W-1] ^ span_reg[DIFF_W-1] ^ den_reg[DIFF_W-1];
            flat_reg <= (den_reg == '0);
        end
    end

    rmmn_div u_div (
        .aclk     (aclk),
        .load     (ctrl.mul),
        .step     (ctrl.div_step),
        .dividend (product),
        .divisor  (den_abs[PIX_W-1:0]),
        .quotient (quo_mag)
    );

    // Restore the sign (truncation toward zero), add the low target, saturate; a flat range gives the low target
    always_comb begin
        quo_signed = neg_reg ? (~{2'b00, quo_mag} + 1'b1) : {2'b00, quo_mag};
        value      = quo_signed + {{(VAL_W-PIX_W){1'b0}}, low_reg};
        if (flat_reg) begin
            result = low_reg;
        end else if (value[VAL_W-1]) begin
            result = PIX_MIN;
        end else if (value[VAL_W-2:PIX_W] != '0) begin
            result = PIX_MAX;
        end else begin
            result = value[PIX_W-1:0];
        end
    end

endmodule

[rtl/rmmn_merge.sv]
// Output stage: gathers the three lane results into one result transaction.
// Holds the result until the downstream side takes it.
// Depends on rmmn_pkg.
module rmmn_merge
    import rmmn_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  logic [PIX_W-1:0]       res_red,
    input  logic [PIX_W-1:0]       res_green,
    input  logic [PIX_W-1:0]       res_blue,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [LANES*PIX_W-1:0] m_tdata,
    output logic                   free
);

    logic                   valid_reg, valid_next;
    logic [LANES*PIX_W-1:0] data_reg;

    // The register is free when empty or when its transaction leaves now
    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load && free) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Pack red lowest, blue highest
    always_ff @(posedge aclk) begin
        if (load && free) begin
            data_reg <= {res_blue, res_green, res_red};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule
